FILE: hw/rtl/ocq_pkg.sv
`default_nettype none

package ocq_pkg;

  localparam int unsigned COUNT_WIDTH = 8;
  localparam int unsigned CH_NUM      = 3;
  localparam int unsigned VALUE_W     = 16;
  localparam int unsigned STATE_W     = 2;
  localparam int unsigned CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_VARIANCE_THRESHOLD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_EXTREMUM_THRESHOLD = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_THRESHOLD = CFG_IDX_W'(2);

  localparam logic [STATE_W-1:0] CODE_EMPTY    = STATE_W'(0);
  localparam logic [STATE_W-1:0] CODE_ARRIVING = STATE_W'(1);
  localparam logic [STATE_W-1:0] CODE_OCCUPIED = STATE_W'(2);

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [VALUE_W-1:0]     value_t;

  typedef struct packed {
    count_t rise;
    count_t settle;
    count_t release_lim;
  } limit_t;

  typedef struct packed {
    value_t variance_value;
    value_t extremum_value;
    value_t distance_value;
    logic   quick_mode;
  } sample_t;

  // Quick mode selects the long per-channel limits; otherwise every limit is one.
  function automatic limit_t channel_limits(input int unsigned ch, input logic quick);
    limit_t lim;
    lim = '{rise: COUNT_WIDTH'(1), settle: COUNT_WIDTH'(1), release_lim: COUNT_WIDTH'(1)};
    if (quick) begin
      case (ch)
        0: lim = '{rise: COUNT_WIDTH'(10), settle: COUNT_WIDTH'(20),
                   release_lim: COUNT_WIDTH'(25)};
        1: lim = '{rise: COUNT_WIDTH'(10), settle: COUNT_WIDTH'(20),
                   release_lim: COUNT_WIDTH'(30)};
        default: lim = '{rise: COUNT_WIDTH'(20), settle: COUNT_WIDTH'(20),
                         release_lim: COUNT_WIDTH'(30)};
      endcase
    end
    return lim;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/ocq_ifs.sv
`default_nettype none

interface ocq_sample_if;
  logic                       valid;
  logic                       ready;
  logic [ocq_pkg::VALUE_W-1:0] variance_value;
  logic [ocq_pkg::VALUE_W-1:0] extremum_value;
  logic [ocq_pkg::VALUE_W-1:0] distance_value;
  logic                       quick_mode;

  modport source (output valid, variance_value, extremum_value, distance_value, quick_mode,
                  input ready);
  modport sink   (input valid, variance_value, extremum_value, distance_value, quick_mode,
                  output ready);
endinterface

interface ocq_result_if;
  logic                        valid;
  logic                        ready;
  logic [ocq_pkg::STATE_W-1:0] variance_state;
  logic [ocq_pkg::STATE_W-1:0] extremum_state;
  logic [ocq_pkg::STATE_W-1:0] distance_state;

  modport source (output valid, variance_state, extremum_state, distance_state,
                  input ready);
  modport sink   (input valid, variance_state, extremum_state, distance_state,
                  output ready);
endinterface

interface ocq_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ocq_pkg::CFG_IDX_W-1:0] index;
  logic [ocq_pkg::VALUE_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/ocq_channel.sv
`default_nettype none

module ocq_channel (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        update,
  input  wire logic [ocq_pkg::VALUE_W-1:0] value,
  input  wire logic [ocq_pkg::VALUE_W-1:0] threshold,
  input  wire ocq_pkg::limit_t             limits,
  output logic [ocq_pkg::STATE_W-1:0]      state_next_code
);
  import ocq_pkg::*;

  typedef enum logic [STATE_W-1:0] {
    EMPTY    = 2'd0,
    ARRIVING = 2'd1,
    OCCUPIED = 2'd2
  } chan_state_t;

  chan_state_t state, state_next;
  count_t      rise_count, rise_count_next;
  count_t      settle_count, settle_count_next;
  count_t      release_count, release_count_next;
  count_t      rise_inc, settle_inc, release_inc;
  logic        seen;

  assign seen        = value > threshold;
  assign rise_inc    = rise_count + COUNT_WIDTH'(1);
  assign settle_inc  = settle_count + COUNT_WIDTH'(1);
  assign release_inc = release_count + COUNT_WIDTH'(1);

  always_comb begin
    state_next         = state;
    rise_count_next    = rise_count;
    settle_count_next  = settle_count;
    release_count_next = release_count;
    if (seen) begin
      if (state != OCCUPIED) begin
        if (rise_inc > limits.rise) begin
          state_next      = OCCUPIED;
          rise_count_next = '0;
        end else begin
          state_next      = ARRIVING;
          rise_count_next = rise_inc;
        end
      end
    end else begin
      unique case (state)
        EMPTY: begin
        end
        ARRIVING: begin
          if (settle_inc > limits.settle) begin
            state_next        = EMPTY;
            settle_count_next = '0;
            rise_count_next   = '0;
          end else begin
            settle_count_next = settle_inc;
          end
        end
        default: begin
          if (release_inc > limits.release_lim) begin
            state_next         = EMPTY;
            release_count_next = '0;
          end else begin
            release_count_next = release_inc;
          end
        end
      endcase
    end
  end

  assign state_next_code = state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= EMPTY;
      rise_count    <= '0;
      settle_count  <= '0;
      release_count <= '0;
    end else if (update) begin
      state         <= state_next;
      rise_count    <= rise_count_next;
      settle_count  <= settle_count_next;
      release_count <= release_count_next;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ocq_cfg_regs.sv
`default_nettype none

module ocq_cfg_regs (
  input  wire logic                   clk,
  input  wire logic                   rst,
  ocq_cfg_if.sink                     cfg,
  output logic [ocq_pkg::VALUE_W-1:0] thresholds [ocq_pkg::CH_NUM]
);
  import ocq_pkg::*;

  value_t variance_threshold, extremum_threshold, distance_threshold;

  assign cfg.ready     = 1'b1;
  assign thresholds[0] = variance_threshold;
  assign thresholds[1] = extremum_threshold;
  assign thresholds[2] = distance_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      variance_threshold <= '0;
      extremum_threshold <= '0;
      distance_threshold <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_VARIANCE_THRESHOLD: variance_threshold <= cfg.data;
        REG_EXTREMUM_THRESHOLD: extremum_threshold <= cfg.data;
        REG_DISTANCE_THRESHOLD: distance_threshold <= cfg.data;
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/three_channel_occupancy_qualifier.sv
// Channel  Direction  Handshake      Contents
// cfg      in         valid/ready    index, data (threshold registers 0..2)
// sample   in         valid/ready    variance, extremum, distance values, quick_mode
// result   out        valid/ready    variance, extremum, distance states
//
// A sample is registered on acceptance and its result is registered on advance.
// One sample per cycle is sustained while results are taken; the input and result
// registers each take a new transaction while the one ahead of them moves on.
// Reset is synchronous and clears all channel states, counters and thresholds.
// A stalled result holds the input register; further samples wait on sample.ready.
`default_nettype none

module three_channel_occupancy_qualifier (
  input  wire logic clk,
  input  wire logic rst,
  ocq_cfg_if.sink       cfg,
  ocq_sample_if.sink    sample,
  ocq_result_if.source  result
);
  import ocq_pkg::*;

  sample_t              hold;
  logic                 hold_valid;
  logic                 advance;
  logic [STATE_W-1:0]   state_next [CH_NUM];
  value_t               thresholds [CH_NUM];
  value_t               values [CH_NUM];

  logic                 res_valid;
  logic [STATE_W-1:0]   variance_state, extremum_state, distance_state;

  assign advance      = hold_valid && (!res_valid || result.ready);
  assign sample.ready = !hold_valid || advance;

  assign values[0] = hold.variance_value;
  assign values[1] = hold.extremum_value;
  assign values[2] = hold.distance_value;

  ocq_cfg_regs u_cfg (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .thresholds (thresholds)
  );

  for (genvar ch = 0; ch < CH_NUM; ch++) begin : g_chan
    ocq_channel u_chan (
      .clk             (clk),
      .rst             (rst),
      .update          (advance),
      .value           (values[ch]),
      .threshold       (thresholds[ch]),
      .limits          (channel_limits(ch, hold.quick_mode)),
      .state_next_code (state_next[ch])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      if (sample.ready) begin
        hold_valid <= sample.valid;
      end
      if (advance) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      hold <= '{variance_value: sample.variance_value,
                extremum_value: sample.extremum_value,
                distance_value: sample.distance_value,
                quick_mode:     sample.quick_mode};
    end
    if (advance) begin
      variance_state <= state_next[0];
      extremum_state <= state_next[1];
      distance_state <= state_next[2];
    end
  end

  assign result.valid          = res_valid;
  assign result.variance_state = variance_state;
  assign result.extremum_state = extremum_state;
  assign result.distance_state = distance_state;

endmodule

`default_nettype wire

FILE: hw/rtl/ocq_checker.sv
`default_nettype none

module ocq_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [ocq_pkg::STATE_W-1:0] out_states [ocq_pkg::CH_NUM]
);
  import ocq_pkg::*;

  logic               have_prev;
  logic [STATE_W-1:0] prev_states [CH_NUM];
  logic               bad_step;
  logic               bad_code;

  always_comb begin
    bad_step = 1'b0;
    bad_code = 1'b0;
    for (int ch = 0; ch < CH_NUM; ch++) begin
      if (prev_states[ch] == CODE_EMPTY && out_states[ch] == CODE_OCCUPIED) begin
        bad_step = 1'b1;
      end
      if (prev_states[ch] == CODE_OCCUPIED && out_states[ch] == CODE_ARRIVING) begin
        bad_step = 1'b1;
      end
      if (out_states[ch] != CODE_EMPTY && out_states[ch] != CODE_ARRIVING &&
          out_states[ch] != CODE_OCCUPIED) begin
        bad_code = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev <= 1'b0;
    end else if (out_valid && out_ready) begin
      have_prev <= 1'b1;
    end
    if (out_valid && out_ready) begin
      prev_states <= out_states;
    end
  end

  a_reset_no_result: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result transaction offered right after reset");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_states[0]) &&
                                $stable(out_states[1]) && $stable(out_states[2]))
    else $error("stalled result transaction changed or dropped");

  a_code_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !bad_code)
    else $error("channel state carries an unused code");

  a_no_skip: assert property (@(posedge clk) disable iff (rst)
    out_valid && have_prev |-> !bad_step)
    else $error("channel skipped arriving or left occupied through arriving");

endmodule

bind three_channel_occupancy_qualifier ocq_checker u_ocq_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (result.valid),
  .out_ready  (result.ready),
  .out_states ('{result.variance_state, result.extremum_state, result.distance_state})
);

`default_nettype wire

FILE: bench/testbench.sv
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ocq_pkg::*;

  localparam int unsigned CLK_HALF        = 5;
  localparam int unsigned RESET_CYCLES    = 6;
  localparam int unsigned IDLE_PERCENT    = 36;
  localparam int unsigned RANDOM_PHASES   = 6;
  localparam int unsigned ITEMS_PER_PHASE = 125;
  localparam int unsigned TAIL_CYCLES     = 8;
  localparam int unsigned STALL_LIMIT     = 2000;

  localparam int CH_VARIANCE = 0;
  localparam int CH_EXTREMUM = 1;
  localparam int CH_DISTANCE = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(3);

  typedef logic [STATE_W-1:0] occ_code_t;

  typedef struct packed {
    occ_code_t variance_state;
    occ_code_t extremum_state;
    occ_code_t distance_state;
  } channel_states_t;

  typedef struct packed {
    value_t    variance_value;
    value_t    extremum_value;
    value_t    distance_value;
    logic      quick_mode;
    logic      known;
    occ_code_t variance_state;
    occ_code_t extremum_state;
    occ_code_t distance_state;
  } stimulus_row_t;

  localparam int DIRECTED_ROWS = 22;
  localparam stimulus_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1, CODE_EMPTY, CODE_EMPTY, CODE_EMPTY},
    '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1, CODE_ARRIVING, CODE_ARRIVING, CODE_ARRIVING},
    '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1, CODE_OCCUPIED, CODE_OCCUPIED, CODE_OCCUPIED},
    '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1, CODE_OCCUPIED, CODE_OCCUPIED, CODE_OCCUPIED},
    '{16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1, CODE_OCCUPIED, CODE_OCCUPIED, CODE_OCCUPIED},
    '{16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1, CODE_EMPTY, CODE_EMPTY, CODE_EMPTY},
    '{16'h0001, 16'h0001, 16'h0001, 1'b0, 1'b1, CODE_ARRIVING, CODE_ARRIVING, CODE_ARRIVING},
    '{16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1, CODE_ARRIVING, CODE_ARRIVING, CODE_ARRIVING},
    '{16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1, CODE_EMPTY, CODE_EMPTY, CODE_EMPTY},
    '{16'hFFFF, 16'h0000, 16'h0001, 1'b0, 1'b1, CODE_ARRIVING, CODE_EMPTY, CODE_ARRIVING},
    '{16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1, CODE_ARRIVING, CODE_EMPTY, CODE_ARRIVING},
    '{16'h8000, 16'h8000, 16'h8000, 1'b0, 1'b0, CODE_EMPTY, CODE_EMPTY, CODE_EMPTY},
    '{16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, CODE_EMPTY, CODE_EMPTY, CODE_EMPTY},
    '{16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, CODE_EMPTY, CODE_EMPTY, CODE_EMPTY},
    '{16'hAAAA, 16'h5555, 16'hAAAA, 1'b0, 1'b0, CODE_EMPTY, CODE_EMPTY, CODE_EMPTY},
    '{16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, CODE_EMPTY, CODE_EMPTY, CODE_EMPTY},
    '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, CODE_EMPTY, CODE_EMPTY, CODE_EMPTY},
    '{16'h5555, 16'hAAAA, 16'h5555, 1'b1, 1'b0, CODE_EMPTY, CODE_EMPTY, CODE_EMPTY},
    '{16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0, CODE_EMPTY, CODE_EMPTY, CODE_EMPTY},
    '{16'h7FFF, 16'h8000, 16'hFFFE, 1'b1, 1'b0, CODE_EMPTY, CODE_EMPTY, CODE_EMPTY},
    '{16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0, CODE_EMPTY, CODE_EMPTY, CODE_EMPTY},
    '{16'hFFFF, 16'h0000, 16'hFFFF, 1'b0, 1'b0, CODE_EMPTY, CODE_EMPTY, CODE_EMPTY}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  ocq_cfg_if    cfg_ch ();
  ocq_sample_if smp_ch ();
  ocq_result_if res_ch ();

  three_channel_occupancy_qualifier dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .sample (smp_ch),
    .result (res_ch)
  );

  value_t    threshold   [CH_NUM] = '{default: '0};
  occ_code_t occ_state   [CH_NUM] = '{default: CODE_EMPTY};
  count_t    rise_cnt    [CH_NUM] = '{default: '0};
  count_t    settle_cnt  [CH_NUM] = '{default: '0};
  count_t    release_cnt [CH_NUM] = '{default: '0};

  channel_states_t expected_states [$];
  int unsigned     mismatches = 0;
  int unsigned     quiet_cycles = 0;
  bit              calm = 1'b0;

  always #(CLK_HALF) clk = ~clk;

  function automatic bit idle_now();
    return !calm && ($urandom_range(99) < IDLE_PERCENT);
  endfunction

  function automatic limit_t hold_limits(input int ch, input logic quick);
    limit_t lim;
    lim.rise        = COUNT_WIDTH'(1);
    lim.settle      = COUNT_WIDTH'(1);
    lim.release_lim = COUNT_WIDTH'(1);
    if (quick) begin
      lim.rise        = (ch == CH_DISTANCE) ? COUNT_WIDTH'(20) : COUNT_WIDTH'(10);
      lim.settle      = COUNT_WIDTH'(20);
      lim.release_lim = (ch == CH_VARIANCE) ? COUNT_WIDTH'(25) : COUNT_WIDTH'(30);
    end
    return lim;
  endfunction

  function automatic void update_channel(input int ch, input value_t level, input logic quick);
    limit_t lim;
    lim = hold_limits(ch, quick);
    if (level > threshold[ch]) begin
      if (occ_state[ch] != CODE_OCCUPIED) begin
        rise_cnt[ch] = rise_cnt[ch] + 1'b1;
        if (rise_cnt[ch] > lim.rise) begin
          occ_state[ch] = CODE_OCCUPIED;
          rise_cnt[ch]  = '0;
        end else begin
          occ_state[ch] = CODE_ARRIVING;
        end
      end
    end else if (occ_state[ch] == CODE_ARRIVING) begin
      settle_cnt[ch] = settle_cnt[ch] + 1'b1;
      if (settle_cnt[ch] > lim.settle) begin
        occ_state[ch]  = CODE_EMPTY;
        settle_cnt[ch] = '0;
        rise_cnt[ch]   = '0;
      end
    end else if (occ_state[ch] != CODE_EMPTY) begin
      release_cnt[ch] = release_cnt[ch] + 1'b1;
      if (release_cnt[ch] > lim.release_lim) begin
        occ_state[ch]   = CODE_EMPTY;
        release_cnt[ch] = '0;
      end
    end
  endfunction

  function automatic channel_states_t qualify_sample(input sample_t s);
    channel_states_t r;
    update_channel(CH_VARIANCE, s.variance_value, s.quick_mode);
    update_channel(CH_EXTREMUM, s.extremum_value, s.quick_mode);
    update_channel(CH_DISTANCE, s.distance_value, s.quick_mode);
    r.variance_state = occ_state[CH_VARIANCE];
    r.extremum_state = occ_state[CH_EXTREMUM];
    r.distance_state = occ_state[CH_DISTANCE];
    return r;
  endfunction

  // Picks a level above thr for a vehicle when thr is not all ones, else at or below thr.
  function automatic value_t pick_level(input value_t thr, input bit above);
    if (above && thr != '1) return value_t'($urandom_range(32'hFFFF, thr + 32'd1));
    if ($urandom_range(7) == 0) return thr;
    return value_t'($urandom_range(thr, 0));
  endfunction

  function automatic void check_field(input string field, input occ_code_t want,
                                      input occ_code_t got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endfunction

  task automatic drain_results();
    while (expected_states.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input value_t val);
    while (idle_now()) begin
      cfg_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx <= REG_DISTANCE_THRESHOLD) threshold[idx] = val;
  endtask

  task automatic load_thresholds(input value_t lv [CH_NUM]);
    write_register(REG_VARIANCE_THRESHOLD, lv[CH_VARIANCE]);
    write_register(REG_EXTREMUM_THRESHOLD, lv[CH_EXTREMUM]);
    write_register(REG_DISTANCE_THRESHOLD, lv[CH_DISTANCE]);
    write_register(REG_SPARE, value_t'($urandom));
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic offer_sample(input sample_t s);
    while (idle_now()) begin
      smp_ch.valid <= 1'b0;
      @(posedge clk);
    end
    smp_ch.valid          <= 1'b1;
    smp_ch.variance_value <= s.variance_value;
    smp_ch.extremum_value <= s.extremum_value;
    smp_ch.distance_value <= s.distance_value;
    smp_ch.quick_mode     <= s.quick_mode;
    @(posedge clk);
    while (!smp_ch.ready) @(posedge clk);
  endtask

  // Each channel alternates runs with and without a vehicle so that the long quick-mode
  // limits are reached; an occasional fully random sample breaks the runs.
  task automatic run_random_phase(input int unsigned count);
    bit          present  [CH_NUM];
    int unsigned run_left [CH_NUM];
    int unsigned mode_left;
    logic        quick;
    sample_t     s;
    present   = '{default: 1'b0};
    run_left  = '{default: 0};
    mode_left = 0;
    quick     = 1'b0;
    for (int unsigned n = 0; n < count; n++) begin
      if (mode_left == 0) begin
        quick     = ($urandom_range(99) < 70);
        mode_left = $urandom_range(80, 10);
      end
      mode_left--;
      for (int ch = 0; ch < CH_NUM; ch++) begin
        if (run_left[ch] == 0) begin
          present[ch]  = ~present[ch];
          run_left[ch] = $urandom_range(40, 1);
        end
        run_left[ch]--;
      end
      s.variance_value = pick_level(threshold[CH_VARIANCE], present[CH_VARIANCE]);
      s.extremum_value = pick_level(threshold[CH_EXTREMUM], present[CH_EXTREMUM]);
      s.distance_value = pick_level(threshold[CH_DISTANCE], present[CH_DISTANCE]);
      s.quick_mode     = quick;
      if ($urandom_range(11) == 0) begin
        {s.variance_value, s.extremum_value} = $urandom;
        s.distance_value = value_t'($urandom);
        s.quick_mode     = 1'($urandom_range(1));
      end
      if (expected_states.size() != 0 && $urandom_range(149) == 0) begin
        smp_ch.valid <= 1'b0;
        drain_results();
      end
      offer_sample(s);
      expected_states.push_back(qualify_sample(s));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= !idle_now();
    end
  end

  always @(posedge clk) begin
    channel_states_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_states.size() == 0) begin
        $error("result transaction with no sample waiting for it");
        mismatches++;
      end else begin
        want = expected_states.pop_front();
        check_field("variance_state", want.variance_state, res_ch.variance_state);
        check_field("extremum_state", want.extremum_state, res_ch.extremum_state);
        check_field("distance_state", want.distance_state, res_ch.distance_state);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (smp_ch.valid && smp_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    stimulus_row_t   row;
    sample_t         s;
    channel_states_t predicted;
    value_t          level_set [CH_NUM];
    cfg_ch.valid          = 1'b0;
    cfg_ch.index          = '0;
    cfg_ch.data           = '0;
    smp_ch.valid          = 1'b0;
    smp_ch.variance_value = '0;
    smp_ch.extremum_value = '0;
    smp_ch.distance_value = '0;
    smp_ch.quick_mode     = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      row              = DIRECTED[i];
      s.variance_value = row.variance_value;
      s.extremum_value = row.extremum_value;
      s.distance_value = row.distance_value;
      s.quick_mode     = row.quick_mode;
      offer_sample(s);
      predicted = qualify_sample(s);
      if (row.known) begin
        predicted.variance_state = row.variance_state;
        predicted.extremum_state = row.extremum_state;
        predicted.distance_state = row.distance_state;
      end
      expected_states.push_back(predicted);
    end
    smp_ch.valid <= 1'b0;
    drain_results();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      for (int ch = 0; ch < CH_NUM; ch++) level_set[ch] = value_t'($urandom);
      case (p)
        0: begin
          level_set[CH_VARIANCE] = '0;
          level_set[CH_EXTREMUM] = '1;
        end
        1: begin
          level_set[CH_VARIANCE] = '1;
          level_set[CH_DISTANCE] = '0;
        end
        3: begin
          level_set[CH_EXTREMUM] = '0;
          level_set[CH_DISTANCE] = '1;
        end
        4: begin
          level_set[CH_VARIANCE] = 16'h8000;
          level_set[CH_EXTREMUM] = 16'h7FFF;
        end
        default: ;
      endcase
      load_thresholds(level_set);
      calm = (p == 2);
      run_random_phase(ITEMS_PER_PHASE);
      smp_ch.valid <= 1'b0;
      drain_results();
    end
    calm = 1'b0;

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_states.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
